/* hdl/wsfr_pkg.sv */
// ----------------------------------------------------------------------------
// wsfr_pkg: shared types and constants of the websocket frame reader
// parse phases, opcodes, error codes, register indexes and the result item
// ----------------------------------------------------------------------------
package wsfr_pkg;

	// parse phases, one-hot
	typedef enum logic [4:0] {
		PH_HDR0    = 5'b00001,
		PH_HDR1    = 5'b00010,
		PH_EXTLEN  = 5'b00100,
		PH_MASKKEY = 5'b01000,
		PH_PAYLOAD = 5'b10000
	} phase_t;

	// opcodes
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;

	// error codes
	localparam logic [2:0] ERR_RESERVED  = 3'd0;
	localparam logic [2:0] ERR_MASK      = 3'd1;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
	localparam logic [2:0] ERR_CONTROL   = 3'd3;
	localparam logic [2:0] ERR_ORPHAN    = 3'd4;
	localparam logic [2:0] ERR_OPCODE    = 3'd5;
	localparam logic [2:0] ERR_MID_FRAG  = 3'd6;
	localparam logic [2:0] ERR_OVERFLOW  = 3'd7;

	// configuration register indexes
	localparam logic REG_MAX_LEN       = 1'b0;
	localparam logic REG_EXPECT_MASKED = 1'b1;

	localparam int unsigned CFG_DATA_W = 32;

	// header constants
	localparam logic [7:0]  RSV_BITS      = 8'h70;
	localparam logic [6:0]  LEN_CODE_16   = 7'd126;
	localparam logic [6:0]  LEN_CODE_64   = 7'd127;
	localparam logic [3:0]  EXT_BYTES_16  = 4'd2;
	localparam logic [3:0]  EXT_BYTES_64  = 4'd8;
	localparam logic [3:0]  KEY_BYTES     = 4'd4;
	localparam logic [31:0] CTRL_MAX_LEN  = 32'd125;
	localparam logic [31:0] MAX_LEN_RESET = 32'd1048576;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic [3:0] msg_opcode;
		logic       is_control;
		logic       end_of_message;
		logic       error;
		logic [2:0] error_code;
	} result_t;

endpackage

/* hdl/wsfr_byte_if.sv */
// ----------------------------------------------------------------------------
// wsfr_byte_if: raw stream byte channel
// valid/ready channel carrying one stream byte per item
// ----------------------------------------------------------------------------
interface wsfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink   (input valid, input in_byte, output ready);
endinterface

/* hdl/wsfr_result_if.sv */
// ----------------------------------------------------------------------------
// wsfr_result_if: deframed result channel
// valid/ready channel carrying one payload byte, marker or error per item
// ----------------------------------------------------------------------------
interface wsfr_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_data;
	logic [3:0] msg_opcode;
	logic       is_control;
	logic       end_of_message;
	logic       error;
	logic [2:0] error_code;

	modport source (output valid, output data_byte, output has_data, output msg_opcode,
		output is_control, output end_of_message, output error, output error_code,
		input ready);
	modport sink   (input valid, input data_byte, input has_data, input msg_opcode,
		input is_control, input end_of_message, input error, input error_code,
		output ready);
endinterface

/* hdl/websocket_frame_reader.sv */
// ----------------------------------------------------------------------------
// websocket_frame_reader: websocket frame deframer
// datapath: an accepted byte is held in the input register, its result in the result register
// throughput: 1 item per cycle unless result.ready stalls, set by the single parse step between the
//   input register and the result register
// reset: arst_n clears parser, message and error state, registers to defaults
// ----------------------------------------------------------------------------
module websocket_frame_reader
	import wsfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	wsfr_byte_if.sink             stream,
	wsfr_result_if.source         result
);

	// configuration registers
	logic [31:0] max_len_q;
	logic        expect_masked_q;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// result register
	logic        out_valid_q;
	result_t     out_res_q;

	// parser state
	phase_t      phase_q;
	logic        fin_q;
	logic [3:0]  opcode_q;
	logic        masked_q;
	logic [3:0]  hdr_cnt_q;
	logic [31:0] len_lo_q;      // low 32 bits of the frame length
	logic        len_hi_q;      // some bit above 31 of the length is set
	logic [31:0] remaining_q;   // payload bytes still to come
	logic [1:0]  key_idx_q;     // payload position modulo 4
	logic [31:0] mask_key_q;
	logic        open_valid_q;
	logic [3:0]  open_op_q;
	logic [31:0] asm_len_q;     // assembled message length, checked against max_len_q
	logic        err_valid_q;
	logic [2:0]  err_code_q;

	// next state
	phase_t      phase_d;
	logic        fin_d;
	logic [3:0]  opcode_d;
	logic        masked_d;
	logic [3:0]  hdr_cnt_d;
	logic [31:0] len_lo_d;
	logic        len_hi_d;
	logic [31:0] remaining_d;
	logic [1:0]  key_idx_d;
	logic [31:0] mask_key_d;
	logic        open_valid_d;
	logic [3:0]  open_op_d;
	logic [31:0] asm_len_d;
	logic        err_valid_d;
	logic [2:0]  err_code_d;
	logic        emit;
	result_t     res;

	logic        advance;
	logic        fire;

	// result register free or being drained this cycle
	assign advance      = !out_valid_q || result.ready;
	assign fire         = valid_s1 && advance;
	assign stream.ready = !valid_s1 || advance;

	// parse step: one byte against the current state
	always_comb begin
		logic        hit;
		logic [2:0]  code;
		logic        len_known;
		logic        begin_pl;
		logic        ctl;
		logic        last;
		logic [32:0] total;
		logic [7:0]  key_byte;

		phase_d      = phase_q;
		fin_d        = fin_q;
		opcode_d     = opcode_q;
		masked_d     = masked_q;
		hdr_cnt_d    = hdr_cnt_q;
		len_lo_d     = len_lo_q;
		len_hi_d     = len_hi_q;
		remaining_d  = remaining_q;
		key_idx_d    = key_idx_q;
		mask_key_d   = mask_key_q;
		open_valid_d = open_valid_q;
		open_op_d    = open_op_q;
		asm_len_d    = asm_len_q;
		err_valid_d  = err_valid_q;
		err_code_d   = err_code_q;
		emit         = 1'b0;
		res          = '0;
		hit          = 1'b0;
		code         = ERR_RESERVED;
		len_known    = 1'b0;
		begin_pl     = 1'b0;
		ctl          = opcode_q[3];
		last         = (remaining_q == 32'd1);
		total        = '0;
		key_byte     = '0;

		if (err_valid_q) begin
			// sticky error: every later byte repeats the error item
			emit           = 1'b1;
			res.error      = 1'b1;
			res.error_code = err_code_q;
		end else begin
			case (phase_q)
				PH_HDR0: begin
					fin_d    = byte_s1[7];
					opcode_d = byte_s1[3:0];
					if ((byte_s1 & RSV_BITS) != 8'h00) begin
						hit  = 1'b1;
						code = ERR_RESERVED;
					end else begin
						phase_d = PH_HDR1;
					end
				end
				PH_HDR1: begin
					masked_d = byte_s1[7];
					if (byte_s1[7] != expect_masked_q) begin
						hit  = 1'b1;
						code = ERR_MASK;
					end else begin
						len_lo_d = '0;
						len_hi_d = 1'b0;
						if (byte_s1[6:0] == LEN_CODE_16 || byte_s1[6:0] == LEN_CODE_64) begin
							hdr_cnt_d = (byte_s1[6:0] == LEN_CODE_16) ? EXT_BYTES_16
								: EXT_BYTES_64;
							phase_d   = PH_EXTLEN;
						end else begin
							len_lo_d  = {25'd0, byte_s1[6:0]};
							len_known = 1'b1;
						end
					end
				end
				PH_EXTLEN: begin
					// bits leaving the low word only matter as "too long"
					len_hi_d  = len_hi_q || (len_lo_q[31:24] != 8'h00);
					len_lo_d  = {len_lo_q[23:0], byte_s1};
					hdr_cnt_d = hdr_cnt_q - 4'd1;
					len_known = (hdr_cnt_d == 4'd0);
				end
				PH_MASKKEY: begin
					mask_key_d = {mask_key_q[23:0], byte_s1};
					hdr_cnt_d  = hdr_cnt_q - 4'd1;
					begin_pl   = (hdr_cnt_d == 4'd0);
				end
				PH_PAYLOAD: begin
					key_byte = masked_q ? mask_key_q[(5'd24 - {key_idx_q, 3'b000}) +: 8]
						: 8'h00;
					emit               = 1'b1;
					res.data_byte      = byte_s1 ^ key_byte;
					res.has_data       = 1'b1;
					res.msg_opcode     = ctl ? opcode_q : open_op_q;
					res.is_control     = ctl;
					res.end_of_message = last && fin_q;
					remaining_d        = remaining_q - 32'd1;
					key_idx_d          = key_idx_q + 2'd1;
					if (last) begin
						phase_d = PH_HDR0;
						if (!ctl && fin_q) begin
							open_valid_d = 1'b0;
							asm_len_d    = '0;
						end
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase

			// length known: frame checks in priority order
			if (len_known) begin
				total = {1'b0, (opcode_q == OP_CONT) ? asm_len_q : 32'd0}
					+ {1'b0, len_lo_d};
				if (len_hi_d || len_lo_d > max_len_q) begin
					hit  = 1'b1;
					code = ERR_TOO_LONG;
				end else if (ctl) begin
					if (!fin_q || len_lo_d > CTRL_MAX_LEN) begin
						hit  = 1'b1;
						code = ERR_CONTROL;
					end
				end else if (opcode_q == OP_CONT) begin
					if (!open_valid_q) begin
						hit  = 1'b1;
						code = ERR_ORPHAN;
					end
				end else if (!(opcode_q inside {OP_TEXT, OP_BINARY})) begin
					hit  = 1'b1;
					code = ERR_OPCODE;
				end else if (open_valid_q) begin
					hit  = 1'b1;
					code = ERR_MID_FRAG;
				end

				if (!hit && !ctl) begin
					if (total > {1'b0, max_len_q}) begin
						hit  = 1'b1;
						code = ERR_OVERFLOW;
					end else begin
						if (opcode_q != OP_CONT) begin
							open_valid_d = 1'b1;
							open_op_d    = opcode_q;
						end
						asm_len_d = total[31:0];
					end
				end

				if (!hit) begin
					if (masked_d) begin
						phase_d    = PH_MASKKEY;
						hdr_cnt_d  = KEY_BYTES;
						mask_key_d = '0;
					end else begin
						begin_pl = 1'b1;
					end
				end
			end

			// header complete: start payload or mark an empty frame
			if (begin_pl) begin
				key_idx_d = '0;
				if (len_lo_d != 32'd0) begin
					phase_d     = PH_PAYLOAD;
					remaining_d = len_lo_d;
				end else begin
					phase_d = PH_HDR0;
					if (ctl) begin
						emit               = 1'b1;
						res.msg_opcode     = opcode_q;
						res.is_control     = 1'b1;
						res.end_of_message = 1'b1;
					end else if (fin_q) begin
						emit               = 1'b1;
						res.msg_opcode     = open_op_d;
						res.end_of_message = 1'b1;
						open_valid_d       = 1'b0;
						asm_len_d          = '0;
					end
				end
			end

			if (hit) begin
				err_valid_d    = 1'b1;
				err_code_d     = code;
				emit           = 1'b1;
				res            = '0;
				res.error      = 1'b1;
				res.error_code = code;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q       <= MAX_LEN_RESET;
			expect_masked_q <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAX_LEN:       max_len_q       <= cfg_data;
				REG_EXPECT_MASKED: expect_masked_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.ready && stream.valid) begin
			byte_s1 <= stream.in_byte;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_res_q <= res;
		end
	end

	// parser state, updated once per parsed item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HDR0;
			fin_q        <= 1'b0;
			opcode_q     <= '0;
			masked_q     <= 1'b0;
			hdr_cnt_q    <= '0;
			len_lo_q     <= '0;
			len_hi_q     <= 1'b0;
			remaining_q  <= '0;
			key_idx_q    <= '0;
			mask_key_q   <= '0;
			open_valid_q <= 1'b0;
			open_op_q    <= '0;
			asm_len_q    <= '0;
			err_valid_q  <= 1'b0;
			err_code_q   <= '0;
		end else if (fire) begin
			phase_q      <= phase_d;
			fin_q        <= fin_d;
			opcode_q     <= opcode_d;
			masked_q     <= masked_d;
			hdr_cnt_q    <= hdr_cnt_d;
			len_lo_q     <= len_lo_d;
			len_hi_q     <= len_hi_d;
			remaining_q  <= remaining_d;
			key_idx_q    <= key_idx_d;
			mask_key_q   <= mask_key_d;
			open_valid_q <= open_valid_d;
			open_op_q    <= open_op_d;
			asm_len_q    <= asm_len_d;
			err_valid_q  <= err_valid_d;
			err_code_q   <= err_code_d;
		end
	end

	// result channel
	assign result.valid          = out_valid_q;
	assign result.data_byte      = out_res_q.data_byte;
	assign result.has_data       = out_res_q.has_data;
	assign result.msg_opcode     = out_res_q.msg_opcode;
	assign result.is_control     = out_res_q.is_control;
	assign result.end_of_message = out_res_q.end_of_message;
	assign result.error          = out_res_q.error;
	assign result.error_code     = out_res_q.error_code;

endmodule
